// File: hw/rtl/tlca_pkg.sv
// ============================================================================
// tlca_pkg: shared types for the rerooted lowest-common-ancestor core
// Transaction payload structs, the command encoding and the sequencer states.
// ============================================================================
package tlca_pkg;

  localparam int NodeW = 11;
  localparam int KindW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_EDGE  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic [NodeW-1:0] query_root;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] ancestor;
    logic             error;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_B_INIT,
    ST_B_POP,
    ST_B_FRD,
    ST_B_DEP,
    ST_B_EDGE,
    ST_B_NB,
    ST_B_CHK,
    ST_B_FIN,
    ST_Q_MA,
    ST_Q_MB,
    ST_Q_LOOP,
    ST_Q_RY,
    ST_Q_CMP,
    ST_Q_R,
    ST_Q_RCHK,
    ST_OUT
  } state_e;

endpackage

// File: hw/rtl/tlca_ram.sv
// ============================================================================
// tlca_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tree_lca_rerooted_core.sv
// ============================================================================
// tree_lca_rerooted_core: lowest common ancestor under a per-query root
// Loads tree edges, builds parent and depth tables breadth-first from node 1,
// and answers (root, a, b) queries by climbing through those tables.
// ============================================================================
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------
//  in      | input     | in_valid_i/in_stall_o | in_item_i  (in_item_t)
//  out     | output    | out_valid_o/out_stall_i| out_item_o (out_item_t)
//  cfg     | input     | cfg_we_i             | cfg_wdata_i (node_count)
//
// An edge transaction is stored without leaving the idle state. A build first
// sweeps the mark memory, then seeds node 1 and, for every node dequeued,
// scans each stored edge for unmarked neighbours to enqueue. A query also
// sweeps the mark memory, then marks the nodes met while climbing toward the
// common ancestor, and last climbs from the query root to a marked node.
// Reset clears the control state only; tables are written before being read.
// A finished result waits in the output register while the next transaction
// is taken; the sequencer only holds when a new result meets a full register.

module tree_lca_rerooted_core
  import tlca_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [NodeW-1:0] cfg_wdata_i
);

  // Node ids run 0..MAX_NODES; compares are done at a width that holds both
  // the node ids and the fixed-width transaction fields.
  localparam int IW        = $clog2(MAX_NODES + 1);
  localparam int CW        = (IW > NodeW) ? IW : NodeW;
  localparam int DW        = $clog2(MAX_NODES);
  localparam int ETW       = $clog2(MAX_NODES);
  localparam int EdgeDepth = MAX_NODES - 1;
  localparam int EAW       = (EdgeDepth > 1) ? $clog2(EdgeDepth) : 1;
  localparam int NodeDepth = MAX_NODES + 1;
  localparam logic [CW-1:0]  MaxC    = CW'(MAX_NODES);
  localparam logic [ETW-1:0] EdgeLim = ETW'(MAX_NODES - 1);
  localparam logic [IW-1:0]  LastIdx = IW'(MAX_NODES);
  localparam logic [IW-1:0]  RootId  = IW'(1);

  state_e           state_q, state_d;
  logic [NodeW-1:0] node_count_q, node_count_d;
  logic             tree_ready_q, tree_ready_d;
  logic [ETW-1:0]   edge_total_q, edge_total_d;
  logic             is_query_q, is_query_d;
  logic [IW-1:0]    clr_q, clr_d;
  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    tail_q, tail_d;
  logic [ETW-1:0]   eidx_q, eidx_d;
  logic [IW-1:0]    f_q, f_d;
  logic [DW-1:0]    fdep_q, fdep_d;
  logic [IW-1:0]    nb_q, nb_d;
  logic [IW-1:0]    x_q, x_d, y_q, y_d, r_q, r_d;
  logic [DW-1:0]    dx_q, dx_d;
  logic [IW-1:0]    px_q, px_d;
  out_item_t        res_q, res_d;
  logic             out_valid_q;
  out_item_t        out_item_q;
  logic             load_out;

  // Memory ports.
  logic            e_we;
  logic [EAW-1:0]  e_waddr, e_raddr;
  logic [2*IW-1:0] e_wdata, e_rdata;
  logic            p_we, d_we, m_we, q_we;
  logic [IW-1:0]   p_waddr, d_waddr, m_waddr, q_waddr, q_raddr, nd_raddr;
  logic [IW-1:0]   p_wdata, p_rdata, q_wdata, q_rdata;
  logic [DW-1:0]   d_wdata, d_rdata;
  logic            m_wdata, m_rdata;

  logic          in_accept;
  logic [CW-1:0] a_c, b_c, r_c, n_c;
  logic          n_ok, edge_ok, query_ok;
  logic [IW-1:0] e_u, e_v, nx, ny;
  logic [DW-1:0] dy;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign a_c = CW'(in_item_i.node_a);
  assign b_c = CW'(in_item_i.node_b);
  assign r_c = CW'(in_item_i.query_root);
  assign n_c = CW'(node_count_q);
  assign n_ok = (n_c != '0) && (n_c <= MaxC);
  assign edge_ok = (a_c != '0) && (a_c <= MaxC) && (b_c != '0) && (b_c <= MaxC) &&
                   (edge_total_q < EdgeLim);
  assign query_ok = tree_ready_q && n_ok &&
                    (a_c != '0) && (a_c <= n_c) && (b_c != '0) && (b_c <= n_c) &&
                    (r_c != '0) && (r_c <= n_c);

  assign e_u = e_rdata[2*IW-1:IW];
  assign e_v = e_rdata[IW-1:0];
  assign dy  = d_rdata;

  // One climb step: the deeper side moves up, or both when level.
  always_comb begin
    nx = x_q;
    ny = y_q;
    if (dx_q > dy) begin
      nx = px_q;
    end else if (dx_q < dy) begin
      ny = p_rdata;
    end else begin
      nx = px_q;
      ny = p_rdata;
    end
  end

  always_comb begin
    state_d      = state_q;
    node_count_d = node_count_q;
    tree_ready_d = tree_ready_q;
    edge_total_d = edge_total_q;
    is_query_d   = is_query_q;
    clr_d        = clr_q;
    head_d       = head_q;
    tail_d       = tail_q;
    eidx_d       = eidx_q;
    f_d          = f_q;
    fdep_d       = fdep_q;
    nb_d         = nb_q;
    x_d          = x_q;
    y_d          = y_q;
    r_d          = r_q;
    dx_d         = dx_q;
    px_d         = px_q;
    res_d        = res_q;
    load_out     = 1'b0;
    e_we    = 1'b0;
    e_waddr = edge_total_q[EAW-1:0];
    e_wdata = {IW'(in_item_i.node_a), IW'(in_item_i.node_b)};
    e_raddr = eidx_q[EAW-1:0];
    p_we    = 1'b0;
    p_waddr = nb_q;
    p_wdata = f_q;
    d_we    = 1'b0;
    d_waddr = nb_q;
    d_wdata = fdep_q + DW'(1);
    m_we    = 1'b0;
    m_waddr = nb_q;
    m_wdata = 1'b1;
    q_we    = 1'b0;
    q_waddr = tail_q;
    q_wdata = nb_q;
    q_raddr = head_q;
    nd_raddr = x_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (kind_e'(in_item_i.kind))
            KIND_EDGE: begin
              if (edge_ok) begin
                e_we         = 1'b1;
                edge_total_d = edge_total_q + ETW'(1);
                tree_ready_d = 1'b0;
              end
            end
            KIND_BUILD: begin
              is_query_d = 1'b0;
              if (n_ok) begin
                clr_d   = '0;
                state_d = ST_CLEAR;
              end else begin
                tree_ready_d = 1'b0;
                res_d        = '{ancestor: '0, error: 1'b1};
                state_d      = ST_OUT;
              end
            end
            KIND_QUERY: begin
              if (query_ok) begin
                x_d        = IW'(in_item_i.node_a);
                y_d        = IW'(in_item_i.node_b);
                r_d        = IW'(in_item_i.query_root);
                is_query_d = 1'b1;
                clr_d      = '0;
                state_d    = ST_CLEAR;
              end else begin
                res_d   = '{ancestor: '0, error: 1'b1};
                state_d = ST_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        m_wdata = 1'b0;
        clr_d   = clr_q + IW'(1);
        if (clr_q == LastIdx) begin
          state_d = is_query_q ? ST_Q_MA : ST_B_INIT;
        end
      end
      ST_B_INIT: begin
        m_we    = 1'b1;
        m_waddr = RootId;
        p_we    = 1'b1;
        p_waddr = RootId;
        p_wdata = '0;
        d_we    = 1'b1;
        d_waddr = RootId;
        d_wdata = '0;
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = RootId;
        head_d  = '0;
        tail_d  = IW'(1);
        state_d = ST_B_POP;
      end
      ST_B_POP: begin
        // The queue length equals the count of nodes reached so far.
        if ((CW'(tail_q) == n_c) || (head_q == tail_q)) begin
          state_d = ST_B_FIN;
        end else begin
          q_raddr = head_q;
          head_d  = head_q + IW'(1);
          state_d = ST_B_FRD;
        end
      end
      ST_B_FRD: begin
        f_d      = q_rdata;
        nd_raddr = q_rdata;
        state_d  = ST_B_DEP;
      end
      ST_B_DEP: begin
        fdep_d  = d_rdata;
        eidx_d  = '0;
        state_d = ST_B_EDGE;
      end
      ST_B_EDGE: begin
        if (eidx_q == edge_total_q) begin
          state_d = ST_B_POP;
        end else begin
          state_d = ST_B_NB;
        end
      end
      ST_B_NB: begin
        eidx_d  = eidx_q + ETW'(1);
        state_d = ST_B_EDGE;
        if ((CW'(e_u) <= n_c) && (CW'(e_v) <= n_c)) begin
          if (e_u == f_q) begin
            nb_d     = e_v;
            nd_raddr = e_v;
            state_d  = ST_B_CHK;
          end else if (e_v == f_q) begin
            nb_d     = e_u;
            nd_raddr = e_u;
            state_d  = ST_B_CHK;
          end
        end
      end
      ST_B_CHK: begin
        if (!m_rdata) begin
          m_we   = 1'b1;
          p_we   = 1'b1;
          d_we   = 1'b1;
          q_we   = 1'b1;
          tail_d = tail_q + IW'(1);
        end
        state_d = ST_B_EDGE;
      end
      ST_B_FIN: begin
        tree_ready_d = (CW'(tail_q) == n_c);
        res_d        = '{ancestor: '0, error: (CW'(tail_q) != n_c)};
        state_d      = ST_OUT;
      end
      ST_Q_MA: begin
        m_we    = 1'b1;
        m_waddr = x_q;
        state_d = ST_Q_MB;
      end
      ST_Q_MB: begin
        m_we    = 1'b1;
        m_waddr = y_q;
        state_d = ST_Q_LOOP;
      end
      ST_Q_LOOP: begin
        if (x_q == y_q) begin
          state_d = ST_Q_R;
        end else begin
          nd_raddr = x_q;
          state_d  = ST_Q_RY;
        end
      end
      ST_Q_RY: begin
        dx_d     = d_rdata;
        px_d     = p_rdata;
        nd_raddr = y_q;
        state_d  = ST_Q_CMP;
      end
      ST_Q_CMP: begin
        if ((CW'(nx) > MaxC) || (CW'(ny) > MaxC)) begin
          res_d   = '{ancestor: '0, error: 1'b0};
          state_d = ST_OUT;
        end else begin
          x_d     = nx;
          y_d     = ny;
          state_d = ST_Q_MA;
        end
      end
      ST_Q_R: begin
        if (CW'(r_q) > MaxC) begin
          res_d   = '{ancestor: NodeW'(x_q), error: 1'b0};
          state_d = ST_OUT;
        end else begin
          nd_raddr = r_q;
          state_d  = ST_Q_RCHK;
        end
      end
      ST_Q_RCHK: begin
        if (m_rdata) begin
          res_d   = '{ancestor: NodeW'(r_q), error: 1'b0};
          state_d = ST_OUT;
        end else if (r_q <= RootId) begin
          res_d   = '{ancestor: NodeW'(x_q), error: 1'b0};
          state_d = ST_OUT;
        end else begin
          r_d     = p_rdata;
          state_d = ST_Q_R;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Configuration is to be written only while the core is idle; the core itself does not enforce this.
    if (cfg_we_i) begin
      node_count_d = cfg_wdata_i;
      tree_ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= NodeW'(1);
      tree_ready_q <= 1'b0;
      edge_total_q <= '0;
      is_query_q   <= 1'b0;
      clr_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      eidx_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      tree_ready_q <= tree_ready_d;
      edge_total_q <= edge_total_d;
      is_query_q   <= is_query_d;
      clr_q        <= clr_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      eidx_q       <= eidx_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    fdep_q <= fdep_d;
    nb_q   <= nb_d;
    x_q    <= x_d;
    y_q    <= y_d;
    r_q    <= r_d;
    dx_q   <= dx_d;
    px_q   <= px_d;
    res_q  <= res_d;
    if (load_out) begin
      out_item_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  tlca_ram #(.WIDTH(2 * IW), .DEPTH(EdgeDepth)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  tlca_ram #(.WIDTH(IW), .DEPTH(NodeDepth)) u_parent_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(nd_raddr), .rdata_o(p_rdata)
  );

  tlca_ram #(.WIDTH(DW), .DEPTH(NodeDepth)) u_depth_ram (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(nd_raddr), .rdata_o(d_rdata)
  );

  tlca_ram #(.WIDTH(1), .DEPTH(NodeDepth)) u_mark_ram (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(nd_raddr), .rdata_o(m_rdata)
  );

  tlca_ram #(.WIDTH(IW), .DEPTH(NodeDepth)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  // A new result never overwrites one that is still waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten");

  // The breadth-first read pointer never passes the write pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_B_POP) |-> (head_q <= tail_q))
    else $error("queue head passed tail");

  // The tree only becomes ready at the end of a build.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tree_ready_q) |-> ($past(state_q) == ST_B_FIN))
    else $error("tree_ready set outside build");

  // A result is produced only after a transaction has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(load_out))
    else $error("result valid without load");

endmodule

// File: tb/tb_tree_lca_rerooted_core.sv
// ============================================================================
// tb_tree_lca_rerooted_core: self-checking bench for the rerooted LCA core
// Loads edges, builds trees of several sizes and fires queries at the core
// with random gaps on both channels. Every build and query answer is checked
// against an in-bench model of the tree tables and the climb rules.
// ============================================================================
module tb_tree_lca_rerooted_core;
  import tlca_pkg::*;

  localparam int MaxNodes = 1024;
  localparam int CycleLimit = 3000000;
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_we;
  logic [NodeW-1:0] cfg_wdata;

  tree_lca_rerooted_core #(.MAX_NODES(MaxNodes)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Model of the core's tables. Index 0 stands for "no parent".
  int unsigned edge_u [0:MaxNodes-1];
  int unsigned edge_v [0:MaxNodes-1];
  int unsigned edges_held;
  int unsigned up_node [0:MaxNodes];
  int unsigned level [0:MaxNodes];
  bit          on_path [0:MaxNodes];
  int unsigned bfs_fifo [0:MaxNodes];
  bit          tree_built;
  int unsigned node_total;

  out_item_t answers_due[$];
  int        mismatches;
  bit        no_gaps;
  longint    cycles;

  // Breadth-first walk from node 1; true when every node was reached.
  function automatic bit grow_tree();
    int unsigned n, head, tail, reached, f, u, v, nb;
    n = node_total;
    head = 0;
    tail = 0;
    reached = 1;
    if (n < 1 || n > MaxNodes) return 1'b0;
    for (int i = 0; i <= MaxNodes; i++) on_path[i] = 1'b0;
    on_path[1] = 1'b1;
    up_node[1] = 0;
    level[1] = 0;
    bfs_fifo[tail++] = 1;
    while (reached != n && head < tail) begin
      f = bfs_fifo[head++];
      for (int i = 0; i < edges_held; i++) begin
        u = edge_u[i];
        v = edge_v[i];
        if (u > n || v > n) continue;
        if (u == f) nb = v;
        else if (v == f) nb = u;
        else continue;
        if (nb >= 1 && !on_path[nb] && tail <= MaxNodes) begin
          on_path[nb] = 1'b1;
          up_node[nb] = f;
          level[nb] = level[f] + 1;
          bfs_fifo[tail++] = nb;
          reached++;
        end
      end
    end
    return reached == n;
  endfunction

  // Mark the a-b path under root 1, then climb from the query root.
  function automatic int unsigned rerooted_lca(int unsigned r, int unsigned a,
                                               int unsigned b);
    int unsigned x, y;
    x = a;
    y = b;
    for (int i = 0; i <= MaxNodes; i++) on_path[i] = 1'b0;
    on_path[x] = 1'b1;
    on_path[y] = 1'b1;
    for (int s = 0; x != y && s < 2 * MaxNodes; s++) begin
      if (level[x] > level[y]) x = up_node[x];
      else if (level[x] < level[y]) y = up_node[y];
      else begin
        x = up_node[x];
        y = up_node[y];
      end
      if (x > MaxNodes || y > MaxNodes) return 0;
      on_path[x] = 1'b1;
      on_path[y] = 1'b1;
    end
    for (int s = 0; s <= MaxNodes; s++) begin
      if (r > MaxNodes) break;
      if (on_path[r]) return r;
      if (r <= 1) break;
      r = up_node[r];
    end
    return x;
  endfunction

  // Updates the model for one accepted transaction; returns 1 with the
  // answer when the transaction produces a result.
  function automatic bit apply_item(input in_item_t it, output out_item_t res);
    int unsigned a, b, r, n;
    a = it.node_a;
    b = it.node_b;
    r = it.query_root;
    n = node_total;
    res = '0;
    case (it.kind)
      KIND_EDGE: begin
        if (a >= 1 && a <= MaxNodes && b >= 1 && b <= MaxNodes &&
            edges_held < MaxNodes - 1) begin
          edge_u[edges_held] = a;
          edge_v[edges_held] = b;
          edges_held++;
          tree_built = 1'b0;
        end
        return 1'b0;
      end
      KIND_BUILD: begin
        tree_built = grow_tree();
        res.error = !tree_built;
        return 1'b1;
      end
      KIND_QUERY: begin
        if (!tree_built || n < 1 || n > MaxNodes || a < 1 || a > n ||
            b < 1 || b > n || r < 1 || r > n) begin
          res.error = 1'b1;
        end else begin
          res.ancestor = NodeW'(rerooted_lca(r, a, b));
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Drives one transaction and returns once the core has taken it. The
  // expected answer, if any, is queued at the accepting edge.
  task automatic send_item(input in_item_t it, input bit typed,
                           input out_item_t typed_res);
    int unsigned gap;
    out_item_t res;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    if (apply_item(it, res)) begin
      if (typed && res != typed_res)
        report_mismatch($sformatf("bench model disagrees with typed row %h", it));
      answers_due.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic send(input logic [KindW-1:0] k, input int unsigned a,
                      input int unsigned b, input int unsigned r);
    in_item_t it;
    it = '{kind: k, node_a: NodeW'(a), node_b: NodeW'(b), query_root: NodeW'(r)};
    send_item(it, 1'b0, '0);
  endtask

  // Register writes happen only with nothing in flight; edge transactions
  // leave no result behind, so a short settle follows the last answer.
  task automatic write_node_count(input logic [NodeW-1:0] val);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    node_total = val;
    tree_built = 1'b0;
  endtask

  typedef struct {
    bit               is_cfg;
    logic [NodeW-1:0] cfg_val;
    in_item_t         it;
    bit               typed;
    out_item_t        res;
  } row_t;

  row_t directed[$];

  function automatic void add_row(input bit is_cfg, input int unsigned v,
                                  input logic [KindW-1:0] k, input int unsigned a,
                                  input int unsigned b, input int unsigned r,
                                  input bit typed, input int unsigned anc,
                                  input bit err);
    row_t rw;
    rw.is_cfg  = is_cfg;
    rw.cfg_val = NodeW'(v);
    rw.it      = '{kind: k, node_a: NodeW'(a), node_b: NodeW'(b),
                   query_root: NodeW'(r)};
    rw.typed   = typed;
    rw.res     = '{ancestor: NodeW'(anc), error: err};
    directed.push_back(rw);
  endfunction

  // Output side: stall for a random number of cycles, then take one result
  // and hold it against the oldest outstanding answer.
  initial begin
    int unsigned k;
    out_stall <= 1'b0;
    @(posedge rst_ni);
    forever begin
      k = pick_gap();
      out_stall <= (k != 0);
      if (k != 0) begin
        repeat (k) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid);
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_item));
      end else begin
        if (out_item.ancestor !== answers_due[0].ancestor)
          report_mismatch($sformatf("ancestor %0d, expected %0d", out_item.ancestor,
                                    answers_due[0].ancestor));
        if (out_item.error !== answers_due[0].error)
          report_mismatch($sformatf("error %b, expected %b", out_item.error,
                                    answers_due[0].error));
        void'(answers_due.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned n, q;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    cycles     = 0;
    mismatches = 0;
    no_gaps    = 1'b0;
    edges_held = 0;
    tree_built = 1'b0;
    node_total = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: query before any build, the unused kind, dropped edges,
    // register extremes, a disconnected graph, self answers, range errors and
    // an edge that invalidates a finished tree.
    add_row(0, 0, KIND_QUERY, 1, 1, 1, 1, 0, 1);
    add_row(0, 0, KindUnused, 2047, 2047, 2047, 0, 0, 0);
    add_row(0, 0, KIND_EDGE, 0, 1, 0, 0, 0, 0);
    add_row(0, 0, KIND_EDGE, 1, 2047, 0, 0, 0, 0);
    add_row(0, 0, KIND_BUILD, 0, 0, 0, 1, 0, 0);
    add_row(0, 0, KIND_QUERY, 1, 1, 1, 1, 1, 0);
    add_row(1, 0, KIND_BUILD, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, KIND_BUILD, 0, 0, 0, 1, 0, 1);
    add_row(1, 2047, KIND_BUILD, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, KIND_BUILD, 2047, 2047, 2047, 1, 0, 1);
    add_row(1, 1024, KIND_BUILD, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, KIND_EDGE, 1, 2, 0, 0, 0, 0);
    add_row(0, 0, KIND_EDGE, 2, 3, 0, 0, 0, 0);
    add_row(0, 0, KIND_EDGE, 4, 1, 0, 0, 0, 0);
    add_row(0, 0, KIND_EDGE, 4, 5, 0, 0, 0, 0);
    add_row(0, 0, KIND_EDGE, 1024, 1023, 0, 0, 0, 0);
    add_row(0, 0, KIND_BUILD, 0, 0, 0, 1, 0, 1);
    add_row(1, 6, KIND_BUILD, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, KIND_EDGE, 5, 6, 0, 0, 0, 0);
    add_row(0, 0, KIND_BUILD, 0, 0, 0, 1, 0, 0);
    add_row(0, 0, KIND_QUERY, 3, 6, 2, 0, 0, 0);
    add_row(0, 0, KIND_QUERY, 6, 6, 6, 1, 6, 0);
    add_row(0, 0, KIND_QUERY, 0, 2, 1, 1, 0, 1);
    add_row(0, 0, KIND_QUERY, 2, 3, 7, 1, 0, 1);
    add_row(0, 0, KIND_EDGE, 6, 2, 0, 0, 0, 0);
    add_row(0, 0, KIND_QUERY, 2, 3, 1, 1, 0, 1);
    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_node_count(directed[i].cfg_val);
      else send_item(directed[i].it, directed[i].typed, directed[i].res);
    end

    // Random phases: a fresh node count, a connecting edge for every node above
    // node 1 plus some noise, a build, then mostly well-formed queries.
    for (int ph = 0; ph < 7; ph++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      n = (ph == 4) ? 24 : $urandom_range(2, 8);
      write_node_count(NodeW'(n));
      for (int v = 2; v <= n; v++) send(KIND_EDGE, v, $urandom_range(1, v - 1), 0);
      for (int j = 0; j < 3; j++) begin
        if ($urandom_range(0, 1)) send(KIND_EDGE, $urandom_range(1, n),
                                       $urandom_range(1, n), 0);
        else send(KindW'($urandom_range(0, 3)), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), $urandom_range(0, 2047));
      end
      send(KIND_BUILD, $urandom_range(0, 2047), $urandom_range(0, 2047), 0);
      q = $urandom_range(8, 12);
      for (int j = 0; j < q; j++) begin
        case ($urandom_range(0, 9))
          0: send(KIND_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 2047));
          1: send(KIND_QUERY, $urandom_range(1, n), n + 1, $urandom_range(0, n));
          2: begin
            send(KIND_EDGE, $urandom_range(1, n), $urandom_range(1, n), 0);
            if ($urandom_range(0, 1)) send(KIND_BUILD, 0, 0, 0);
          end
          default: send(KIND_QUERY, $urandom_range(1, n), $urandom_range(1, n),
                        $urandom_range(1, n));
        endcase
      end
    end

    // A small chain tree on top of the edges already stored, its edges sent
    // back to back, then built and queried.
    write_node_count(NodeW'(4));
    no_gaps = 1'b1;
    send(KIND_EDGE, 1, 2, 0);
    send(KIND_EDGE, 2, 3, 0);
    send(KIND_EDGE, 3, 4, 0);
    no_gaps = 1'b0;
    send(KIND_BUILD, 0, 0, 0);
    for (int j = 0; j < 6; j++)
      send(KIND_QUERY, $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4));

    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tlca_pkg.sv
hw/rtl/tlca_ram.sv
hw/rtl/tree_lca_rerooted_core.sv
tb/tb_tree_lca_rerooted_core.sv
